// ===== rtl/hdps_pkg.sv =====
// Shared types and constants for the Hausdorff distance block.
// No dependencies; all other files import this package.
package hdps_pkg;

  // store geometry
  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned PTR_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = PTR_W + 1;

  // field widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SQ_W     = 34;
  localparam int unsigned ROOT_W   = 17;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MAG_W    = COORD_W;
  localparam int unsigned PROD_W   = 2 * MAG_W;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);

  // action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_STORE_A = 2'd0,
    ACT_STORE_B = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  // one stored point
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

endpackage

// ===== rtl/hdps_if.sv =====
// Valid/ready channel interfaces for point words and result words.
// Depends on hdps_pkg.
interface hdps_in_if import hdps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

interface hdps_out_if import hdps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SQ_W-1:0]     directed_ab_sq;
  logic [SQ_W-1:0]     directed_ba_sq;
  logic [SQ_W-1:0]     hausdorff_sq;
  logic [ROOT_W-1:0]   hausdorff_root;
  logic [STATUS_W-1:0] status;

  modport source (output valid, directed_ab_sq, directed_ba_sq, hausdorff_sq,
                  hausdorff_root, status, input ready);
  modport sink   (input valid, directed_ab_sq, directed_ba_sq, hausdorff_sq,
                  hausdorff_root, status, output ready);
endinterface

// ===== rtl/hausdorff_distance_point_sets.sv =====
// Hausdorff distance of two 3D point sets by exhaustive nearest-neighbor search.
// Depends on hdps_pkg, hdps_if (hdps_in_if, hdps_out_if) and hdps_sqrt.
//
// Store and clear words are taken in the idle state. A compute word walks every ordered
// pair of points in both directions through one shared 16x16 squarer, stepping
// through each pair as store read, three axis squares, and accumulate and compare,
// then takes the square root and waits for the result register to drain; a
// compute with an empty set goes straight to the done state. Words are not accepted while a
// compute runs. A finished result waits in an output register, and store and
// clear words are accepted meanwhile.
module hausdorff_distance_point_sets import hdps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hdps_in_if.sink    in_i,
  hdps_out_if.source out_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_AX    = 3'd2;
  localparam logic [2:0] S_AY    = 3'd3;
  localparam logic [2:0] S_AZ    = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_ROOT  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic             ovf_q, ovf_d;
  logic             dir_q, dir_d;
  logic [PTR_W-1:0] i_q, i_d, j_q, j_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;

  logic [PROD_W-1:0] prod_q, prod_d;
  logic [SQ_W-1:0]   acc_q, acc_d, near_q, near_d, best_q, best_d;
  logic [SQ_W-1:0]   ab_q, ab_d, ba_q, ba_d;
  logic [ROOT_W-1:0] root_q, root_d;

  point_t mem_a [MAX_POINTS];
  point_t mem_b [MAX_POINTS];
  point_t rd_a_q, rd_b_q, from_pt, to_pt, in_pt;
  logic   wr_a, wr_b;
  logic [PTR_W-1:0] addr_a, addr_b;

  logic                      accept, load_out;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          mag;
  logic [SQ_W-1:0]           pair_dist, cand, best_new, h_sq, h_new;
  logic [CNT_W-1:0]          nf, nt;
  logic                      last_i, last_j, sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]         sqrt_root;

  assign accept  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_pt   = '{x: in_i.coord_x, y: in_i.coord_y, z: in_i.coord_z};

  // point stores
  assign wr_a   = accept && (action_e'(in_i.action) == ACT_STORE_A) && (cnt_a_q < CNT_FULL);
  assign wr_b   = accept && (action_e'(in_i.action) == ACT_STORE_B) && (cnt_b_q < CNT_FULL);
  assign addr_a = dir_q ? j_q : i_q;
  assign addr_b = dir_q ? i_q : j_q;

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[cnt_a_q[PTR_W-1:0]] <= in_pt;
    end
    rd_a_q <= mem_a[addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[cnt_b_q[PTR_W-1:0]] <= in_pt;
    end
    rd_b_q <= mem_b[addr_b];
  end

  // search direction selects source and target set
  assign from_pt = dir_q ? rd_b_q : rd_a_q;
  assign to_pt   = dir_q ? rd_a_q : rd_b_q;
  assign nf      = dir_q ? cnt_b_q : cnt_a_q;
  assign nt      = dir_q ? cnt_a_q : cnt_b_q;
  assign last_i  = ({1'b0, i_q} == nf - 1'b1);
  assign last_j  = ({1'b0, j_q} == nt - 1'b1);

  // axis difference for the shared squarer
  always_comb begin
    unique case (state_q)
      S_AY:    diff = {from_pt.y[COORD_W-1], from_pt.y} - {to_pt.y[COORD_W-1], to_pt.y};
      S_AZ:    diff = {from_pt.z[COORD_W-1], from_pt.z} - {to_pt.z[COORD_W-1], to_pt.z};
      default: diff = {from_pt.x[COORD_W-1], from_pt.x} - {to_pt.x[COORD_W-1], to_pt.x};
    endcase
  end
  assign mag = diff[COORD_W] ? (COORD_W+1)'(0) - diff : diff;

  // distance, nearest and farthest-nearest
  assign pair_dist = acc_q + SQ_W'(prod_q);
  assign cand      = (pair_dist < near_q) ? pair_dist : near_q;
  assign best_new  = (cand > best_q) ? cand : best_q;
  assign h_new     = (ab_q > best_new) ? ab_q : best_new;
  assign h_sq      = (ab_q > ba_q) ? ab_q : ba_q;

  assign sqrt_start = (state_q == S_CMP) && last_j && last_i && dir_q;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  hdps_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (h_new),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    ovf_d       = ovf_q;
    dir_d       = dir_q;
    i_d         = i_q;
    j_d         = j_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    near_d      = near_q;
    best_d      = best_q;
    ab_d        = ab_q;
    ba_d        = ba_q;
    root_d      = root_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_e'(in_i.action))
            ACT_STORE_A: begin
              if (wr_a) cnt_a_d = cnt_a_q + 1'b1;
              else      ovf_d   = 1'b1;
            end
            ACT_STORE_B: begin
              if (wr_b) cnt_b_d = cnt_b_q + 1'b1;
              else      ovf_d   = 1'b1;
            end
            ACT_CLEAR: begin
              cnt_a_d = '0;
              cnt_b_d = '0;
              ovf_d   = 1'b0;
            end
            default: begin
              dir_d  = 1'b0;
              i_d    = '0;
              j_d    = '0;
              best_d = '0;
              near_d = '1;
              if (cnt_a_q == '0 || cnt_b_q == '0) begin
                status_d = ST_EMPTY;
                ab_d     = '0;
                ba_d     = '0;
                root_d   = '0;
                state_d  = S_DONE;
              end else begin
                status_d = ovf_q ? ST_DROPPED : ST_OK;
                state_d  = S_ISSUE;
              end
            end
          endcase
        end
      end
      S_ISSUE: state_d = S_AX;
      S_AX: begin
        prod_d  = mag[MAG_W-1:0] * mag[MAG_W-1:0];
        state_d = S_AY;
      end
      S_AY: begin
        prod_d  = mag[MAG_W-1:0] * mag[MAG_W-1:0];
        acc_d   = SQ_W'(prod_q);
        state_d = S_AZ;
      end
      S_AZ: begin
        prod_d  = mag[MAG_W-1:0] * mag[MAG_W-1:0];
        acc_d   = acc_q + SQ_W'(prod_q);
        state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_ISSUE;
        if (!last_j) begin
          near_d = cand;
          j_d    = j_q + 1'b1;
        end else begin
          near_d = '1;
          j_d    = '0;
          if (!last_i) begin
            best_d = best_new;
            i_d    = i_q + 1'b1;
          end else if (!dir_q) begin
            ab_d   = best_new;
            best_d = '0;
            i_d    = '0;
            dir_d  = 1'b1;
          end else begin
            ba_d    = best_new;
            state_d = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (sqrt_done) begin
          root_d  = sqrt_root;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ovf_q       <= 1'b0;
      dir_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ovf_q       <= ovf_d;
      dir_q       <= dir_d;
      i_q         <= i_d;
      j_q         <= j_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    near_q <= near_d;
    best_q <= best_d;
    ab_q   <= ab_d;
    ba_q   <= ba_d;
    root_q <= root_d;
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.directed_ab_sq <= ab_q;
      out_o.directed_ba_sq <= ba_q;
      out_o.hausdorff_sq   <= h_sq;
      out_o.hausdorff_root <= root_q;
      out_o.status         <= status_q;
    end
  end

  assign out_o.valid = out_valid_q;

  // the pair walk stays inside the filled part of both stores
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> ({1'b0, i_q} < nf) && ({1'b0, j_q} < nt))
    else $error("pair index beyond store fill");

  // counts never pass the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CNT_FULL) && (cnt_b_q <= CNT_FULL))
    else $error("store count overflow");

  // an empty-set result carries zero distances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_EMPTY) |->
      (out_o.hausdorff_sq == '0) && (out_o.hausdorff_root == '0))
    else $error("empty result with nonzero distance");

  // a fresh result takes the larger directed value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      (out_o.hausdorff_sq >= out_o.directed_ab_sq) &&
      (out_o.hausdorff_sq >= out_o.directed_ba_sq))
    else $error("hausdorff value below a directed value");

endmodule

// ===== rtl/hdps_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on hdps_pkg.
module hdps_sqrt import hdps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned ITER_W = $clog2(ROOT_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROOT_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [SQ_W-1:0]   rem_q, rem_d;
  logic [SQ_W:0]     root_q, root_d;
  logic [SQ_W-1:0]   bit_q, bit_d;
  logic [SQ_W:0]     trial;
  logic              fits;

  // one restoring step
  assign trial = root_q + {1'b0, bit_q};
  assign fits  = {1'b0, rem_q} >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      rem_d  = radicand_i;
      root_d = '0;
      bit_d  = SQ_W'(1) << (2 * (ROOT_W - 1));
    end else if (busy_q) begin
      if (fits) begin
        rem_d  = rem_q - trial[SQ_W-1:0];
        root_d = (root_q >> 1) + {1'b0, bit_q};
      end else begin
        root_d = root_q >> 1;
      end
      bit_d  = bit_q >> 2;
      iter_d = iter_q + 1'b1;
      if (iter_q == ITER_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  // root register holds the final value the cycle after the last step
  assign done_o = done_q;
  assign root_o = root_q[ROOT_W-1:0];

endmodule
